// ----- rtl/afm_pkg.sv -----
// Shared word types, register indexes and the sine table of the audio frame mixer.
package afm_pkg;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               pcm_valid;
        logic               tone_start;
    } afm_in_t;

    typedef struct packed {
        logic [31:0] left_slot;
        logic [31:0] right_slot;
    } afm_out_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_LENGTH = 2'd1;

    localparam logic [6:0]  VOLUME_RESET      = 7'd25;
    localparam logic [6:0]  VOLUME_MAX        = 7'd100;
    localparam logic [19:0] TONE_LENGTH_RESET = 20'd48000;

    localparam int ROM_SIZE = 48;

    localparam logic signed [15:0] SINE_ROM [0:ROM_SIZE-1] = '{
        16'sd0,     16'sd535,   16'sd1060,  16'sd1567,  16'sd2048,  16'sd2493,
        16'sd2896,  16'sd3250,  16'sd3547,  16'sd3784,  16'sd3956,  16'sd4061,
        16'sd4096,  16'sd4061,  16'sd3956,  16'sd3784,  16'sd3547,  16'sd3250,
        16'sd2896,  16'sd2493,  16'sd2048,  16'sd1567,  16'sd1060,  16'sd535,
        16'sd0,    -16'sd535,  -16'sd1060, -16'sd1567, -16'sd2048, -16'sd2493,
        -16'sd2896, -16'sd3250, -16'sd3547, -16'sd3784, -16'sd3956, -16'sd4061,
        -16'sd4096, -16'sd4061, -16'sd3956, -16'sd3784, -16'sd3547, -16'sd3250,
        -16'sd2896, -16'sd2493, -16'sd2048, -16'sd1567, -16'sd1060, -16'sd535
    };

    // The phase may run past one period of the table, so it is folded back first.
    function automatic logic signed [15:0] sine_value(input logic [7:0] phase);
        logic [7:0] folded;
        folded = phase;
        for (int i = 0; i < 5; i++) begin
            if (folded >= 8'(ROM_SIZE)) begin
                folded = folded - 8'(ROM_SIZE);
            end
        end
        return SINE_ROM[folded[5:0]];
    endfunction

endpackage

// ----- rtl/audio_frame_mixer_tone_volume.sv -----
// Top level of the audio frame mixer with test tone and volume control.
//
// Each input word on s_valid/s_ready/s_data is one stereo frame: a PCM pair,
// a flag saying whether the pair is present and a tone restart flag. Each
// output word on m_valid/m_ready/m_data carries the two 32-bit I2S slots,
// both holding the mixed, volume-scaled sample in their upper 16 bits.
// The block has three register stages: sample selection with the tone
// counter, the volume multiply, and the divide by one hundred into the
// output register. One word is taken every cycle while the receiver keeps
// m_ready high. When the receiver stalls, words stay in their stages and
// s_ready drops only once every stage is full. Configuration is written
// through cfg_write, cfg_index and cfg_data: index 0 sets the volume in
// percent, saturating at 100, and index 1 the tone length in frames. Reset
// empties the pipeline, stops the tone and returns the volume to 25 and
// the tone length to 48000.
module audio_frame_mixer_tone_volume #(
    parameter int TONE_ENTRIES = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  afm_pkg::afm_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output afm_pkg::afm_out_t                   m_data,
    input  logic                                cfg_write,
    input  logic [afm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [afm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import afm_pkg::*;

    logic [6:0]         volume_reg;
    logic [19:0]        tone_length_reg;
    logic               sample_valid;
    logic               sample_ready;
    logic signed [15:0] sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg      <= VOLUME_RESET;
            tone_length_reg <= TONE_LENGTH_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_VOLUME: begin
                    volume_reg <= (cfg_data[6:0] > VOLUME_MAX) ? VOLUME_MAX : cfg_data[6:0];
                end
                REG_TONE_LENGTH: begin
                    tone_length_reg <= cfg_data[19:0];
                end
                default: begin
                end
            endcase
        end
    end

    afm_source #(
        .TONE_ENTRIES (TONE_ENTRIES)
    ) u_source (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .tone_length (tone_length_reg),
        .out_valid   (sample_valid),
        .out_ready   (sample_ready),
        .out_sample  (sample)
    );

    afm_scale u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (sample_valid),
        .in_ready       (sample_ready),
        .in_sample      (sample),
        .volume_percent (volume_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

// ----- rtl/afm_source.sv -----
// Tone state and sample selection stage of the audio frame mixer.
module afm_source #(
    parameter int TONE_ENTRIES = 48
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  afm_pkg::afm_in_t          s_data,
    input  logic [19:0]               tone_length,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [15:0]        out_sample
);
    import afm_pkg::*;

    localparam int IDX_W = $clog2(TONE_ENTRIES);

    logic [19:0]        tone_remaining_reg;
    logic [19:0]        tone_remaining_next;
    logic [IDX_W-1:0]   tone_index_reg;
    logic [IDX_W-1:0]   tone_index_next;
    logic               valid_reg;
    logic signed [15:0] sample_reg;
    logic signed [15:0] sample_next;

    logic               accept;
    logic [19:0]        remaining_eff;
    logic [IDX_W-1:0]   index_eff;
    logic signed [16:0] pcm_sum;
    logic signed [16:0] pcm_rounded;

    assign s_ready    = !valid_reg || out_ready;
    assign accept     = s_valid && s_ready;
    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;

    always_comb begin
        remaining_eff = s_data.tone_start ? tone_length : tone_remaining_reg;
        index_eff     = s_data.tone_start ? '0 : tone_index_reg;
        pcm_sum       = 17'(s_data.left_sample) + 17'(s_data.right_sample);
        // Adding one to a negative sum makes the halving truncate toward zero.
        pcm_rounded   = pcm_sum + 17'(pcm_sum[16]);

        tone_remaining_next = remaining_eff;
        tone_index_next     = index_eff;
        sample_next         = 16'sd0;
        if (remaining_eff != 20'd0) begin
            sample_next         = sine_value(8'(index_eff));
            tone_remaining_next = remaining_eff - 20'd1;
            if (index_eff == IDX_W'(TONE_ENTRIES - 1)) begin
                tone_index_next = '0;
            end else begin
                tone_index_next = index_eff + IDX_W'(1);
            end
        end else if (s_data.pcm_valid) begin
            sample_next = $signed(pcm_rounded[16:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= 1'b0;
            tone_remaining_reg <= '0;
            tone_index_reg     <= '0;
        end else begin
            if (s_ready) begin
                valid_reg <= s_valid;
            end
            if (accept) begin
                tone_remaining_reg <= tone_remaining_next;
                tone_index_reg     <= tone_index_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= sample_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        tone_index_reg <= IDX_W'(TONE_ENTRIES - 1))
        else $error("Tone phase has left its period.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_data.tone_start && tone_remaining_reg != 20'd0
        |=> tone_remaining_reg == $past(tone_remaining_reg) - 20'd1)
        else $error("Tone counter did not count down on a tone word.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.tone_start && tone_length != 20'd0
        |=> valid_reg && sample_reg == 16'sd0 && tone_index_reg == IDX_W'(1))
        else $error("Tone restart did not begin at phase zero.");

endmodule

// ----- rtl/afm_scale.sv -----
// Volume multiply, divide by one hundred and slot packing stages of the audio frame mixer.
module afm_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  in_sample,
    input  logic [6:0]          volume_percent,
    output logic                m_valid,
    input  logic                m_ready,
    output afm_pkg::afm_out_t   m_data
);
    import afm_pkg::*;

    // floor(x / 100) equals (x * RECIP_100) >> RECIP_SHIFT for every x below 2**22.
    localparam logic [22:0] RECIP_100   = 23'd5368710;
    localparam int          RECIP_SHIFT = 29;

    logic               product_valid_reg;
    logic signed [23:0] product_reg;
    logic signed [23:0] product_next;
    logic               product_ready;
    logic               out_valid_reg;
    afm_out_t           out_data_reg;
    afm_out_t           out_data_next;
    logic               out_ready;

    logic               product_neg;
    logic [21:0]        product_mag;
    logic [44:0]        quotient_full;
    logic [15:0]        quotient;
    logic [15:0]        scaled;

    assign out_ready     = !out_valid_reg || m_ready;
    assign product_ready = !product_valid_reg || out_ready;
    assign in_ready      = product_ready;
    assign m_valid       = out_valid_reg;
    assign m_data        = out_data_reg;

    always_comb begin
        product_next  = 24'(in_sample) * $signed({1'b0, volume_percent});
        product_neg   = product_reg[23];
        product_mag   = product_neg ? 22'(-product_reg) : 22'(product_reg);
        quotient_full = 45'(product_mag) * 45'(RECIP_100);
        quotient      = quotient_full[RECIP_SHIFT +: 16];
        scaled        = product_neg ? 16'(~quotient + 16'd1) : quotient;
        out_data_next.left_slot  = {scaled, 16'h0000};
        out_data_next.right_slot = {scaled, 16'h0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            product_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (product_ready) begin
                product_valid_reg <= in_valid;
            end
            if (out_ready) begin
                out_valid_reg <= product_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && product_ready) begin
            product_reg <= product_next;
        end
        if (product_valid_reg && out_ready) begin
            out_data_reg <= out_data_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.left_slot[15:0] == 16'h0000
            && out_data_reg.left_slot == out_data_reg.right_slot)
        else $error("Output slots disagree or carry low bits.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && product_ready && volume_percent == 7'd0 |=> product_reg == 24'sd0)
        else $error("Zero volume gave a non-zero product.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        product_valid_reg && out_valid_reg && !m_ready
        |=> product_valid_reg && $stable(product_reg))
        else $error("Product stage moved while the output was stalled.");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the audio frame mixer: predicts every output word and compares it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import afm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_FRAMES    = 235;

    class slot_tracker;
        int unsigned volume;
        int unsigned tone_length;
        int unsigned frames_left;
        int unsigned rom_step;
        int unsigned mismatches;
        afm_out_t    pending_slots[$];

        function new();
            volume      = 25;
            tone_length = 48000;
            frames_left = 0;
            rom_step    = 0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VOLUME: begin
                    volume = (data[6:0] > 7'd100) ? 100 : int'(data[6:0]);
                end
                REG_TONE_LENGTH: begin
                    tone_length = int'(data);
                end
                default: begin
                end
            endcase
        endfunction

        function int sine_at(int unsigned phase);
            int unsigned quarter;
            int          magnitude;
            quarter = phase % 24;
            if (quarter > 12) begin
                quarter = 24 - quarter;
            end
            case (quarter)
                0:  magnitude = 0;
                1:  magnitude = 535;
                2:  magnitude = 1060;
                3:  magnitude = 1567;
                4:  magnitude = 2048;
                5:  magnitude = 2493;
                6:  magnitude = 2896;
                7:  magnitude = 3250;
                8:  magnitude = 3547;
                9:  magnitude = 3784;
                10: magnitude = 3956;
                11: magnitude = 4061;
                default: magnitude = 4096;
            endcase
            return ((phase % 48) >= 24) ? -magnitude : magnitude;
        endfunction

        function void note_frame(afm_in_t frame);
            int       level;
            int       left;
            int       right;
            afm_out_t slots;
            level = 0;
            left  = $signed(frame.left_sample);
            right = $signed(frame.right_sample);
            if (frame.tone_start) begin
                frames_left = tone_length;
                rom_step    = 0;
            end
            if (frames_left != 0) begin
                level       = sine_at(rom_step);
                rom_step    = (rom_step + 1) % 48;
                frames_left = frames_left - 1;
            end else if (frame.pcm_valid) begin
                level = (left + right) / 2;
            end
            level = level * int'(volume) / 100;
            slots.left_slot  = {level[15:0], 16'h0000};
            slots.right_slot = {level[15:0], 16'h0000};
            pending_slots.push_back(slots);
        endfunction

        function void check_slots(afm_out_t got);
            afm_out_t want;
            if (pending_slots.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected output word %h at %0t", got, $realtime);
                end
                mismatches++;
            end else begin
                want = pending_slots.pop_front();
                if (got.left_slot !== want.left_slot || got.right_slot !== want.right_slot) begin
                    if (mismatches < 10) begin
                        $display("slot mismatch at %0t: left %h expected %h, right %h expected %h",
                                 $realtime, got.left_slot, want.left_slot,
                                 got.right_slot, want.right_slot);
                    end
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    afm_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    afm_out_t               m_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    slot_tracker mixer = new();
    int          gap_limit     = 10;
    int          stall_request = 0;
    int          idle_cycles   = 0;

    audio_frame_mixer_tone_volume u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                mixer.note_frame(s_data);
            end
            if (m_valid && m_ready) begin
                mixer.check_slots(m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int wait_cycles;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            wait_cycles = $urandom_range(0, gap_limit);
            if (stall_request > 0) begin
                wait_cycles   = stall_request;
                stall_request = 0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic afm_in_t frame_of(logic signed [15:0] left, logic signed [15:0] right,
                                         logic pcm, logic restart);
        afm_in_t frame;
        frame.left_sample  = left;
        frame.right_sample = right;
        frame.pcm_valid    = pcm;
        frame.tone_start   = restart;
        return frame;
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic afm_in_t random_frame(int restart_odds);
        return frame_of(random_sample(), random_sample(), $urandom_range(0, 9) != 0,
                        $urandom_range(0, restart_odds) == 0);
    endfunction

    task automatic send_frame(input afm_in_t frame);
        int gap;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= frame;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        mixer.set_register(idx, data);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [6:0] vol, input logic [19:0] len);
        do @(posedge aclk); while (mixer.pending_slots.size() != 0);
        repeat (4) @(posedge aclk);
        write_register(REG_VOLUME, {13'($urandom), vol});
        write_register(REG_SPARE_LO, 20'($urandom));
        write_register(REG_TONE_LENGTH, len);
        write_register(REG_SPARE_HI, 20'($urandom));
        cfg_write <= 1'b0;
    endtask

    initial begin
        logic [6:0]  volumes[8];
        logic [19:0] lengths[8];
        int          odds;
        volumes = '{7'd127, 7'd0, 7'd100, 7'd50, 7'd1, 7'd99, 7'd101, 7'd37};
        lengths = '{20'd0, 20'd5, 20'd1, 20'd60, 20'hFFFFF, 20'd3, 20'd200, 20'd0};
        volumes[7] = 7'($urandom_range(0, 127));
        lengths[7] = 20'($urandom_range(2, 300));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Power-on settings, then the test tone running over live PCM.
        send_frame(frame_of(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0));
        send_frame(frame_of(16'sh8000, 16'sh8000, 1'b1, 1'b0));
        send_frame(frame_of(16'sh7FFF, 16'sh8000, 1'b1, 1'b0));
        send_frame(frame_of(-16'sd1, 16'sd0, 1'b1, 1'b0));
        send_frame(frame_of(-16'sd3, 16'sd0, 1'b1, 1'b0));
        send_frame(frame_of(16'sd3, 16'sd0, 1'b1, 1'b0));
        send_frame(frame_of(16'sd1234, -16'sd77, 1'b0, 1'b0));
        send_frame(frame_of(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1));
        repeat (14) send_frame(random_frame(1000));
        s_valid <= 1'b0;

        for (int phase = 0; phase < 8; phase++) begin
            gap_limit = (phase == 2 || phase == 5) ? 0 : 10;
            apply_setting(volumes[phase], lengths[phase]);
            if (phase == 0) begin
                send_frame(frame_of(16'sh8000, 16'sh8000, 1'b1, 1'b1));
                send_frame(frame_of(16'sh7FFF, 16'sh7FFE, 1'b1, 1'b0));
                send_frame(frame_of(-16'sd5, 16'sd2, 1'b1, 1'b0));
                send_frame(frame_of(16'sd999, 16'sd999, 1'b0, 1'b1));
            end
            if (phase == 2) begin
                stall_request = HOLD_OFF_CYCLES;
            end
            odds = (lengths[phase] > 20'd100) ? 120 : 12;
            repeat (PHASE_FRAMES) send_frame(random_frame(odds));
            s_valid <= 1'b0;
        end

        do @(posedge aclk); while (mixer.pending_slots.size() != 0);
        repeat (8) @(posedge aclk);
        if (mixer.mismatches == 0 && mixer.pending_slots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/afm_pkg.sv
rtl/afm_source.sv
rtl/afm_scale.sv
rtl/audio_frame_mixer_tone_volume.sv
bench/testbench.sv
